/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define KBT_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("kbt check failed");

// antecedent implies consequent in the same cycle
`define KBT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kbt check failed");

`endif

/* sv/kbt_pkg.sv */
package kbt_pkg;

   localparam int KEY_BITS_DEF        = 64;
   localparam int BUCKET_CAPACITY_DEF = 16;
   localparam int MAX_NEIGHBORS_DEF   = 16;
   localparam int RESULT_LIMIT        = 16;

   localparam logic [2:0] ACT_INSERT       = 3'd0;
   localparam logic [2:0] ACT_REMOVE       = 3'd1;
   localparam logic [2:0] ACT_UPDATE       = 3'd2;
   localparam logic [2:0] ACT_UPDATE_KNOWN = 3'd3;
   localparam logic [2:0] ACT_PROBE        = 3'd4;
   localparam logic [2:0] ACT_QUERY        = 3'd5;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_PRESENT = 3'd1;
   localparam logic [2:0] ST_ABSENT  = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_HOME    = 3'd4;

   // index of the highest set bit, two-level search over bytes
   function automatic logic [5:0] top_bit64(logic [63:0] d);
      logic [7:0] grp;
      logic [2:0] g;
      logic [7:0] byt;
      logic [2:0] p;
      for (int k = 0; k < 8; k++) begin
         grp[k] = |d[8*k +: 8];
      end
      g = 3'd0;
      for (int k = 0; k < 8; k++) begin
         if (grp[k]) g = 3'(k);
      end
      byt = d[{g, 3'b000} +: 8];
      p = 3'd0;
      for (int k = 0; k < 8; k++) begin
         if (byt[k]) p = 3'(k);
      end
      return {g, p};
   endfunction

endpackage

/* sv/kbt_ram.sv */
module kbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/kbt_closer.sv */
module kbt_closer #(
   parameter int KEY_BITS = kbt_pkg::KEY_BITS_DEF
) (
   input  logic [63:0]         a_ident,
   input  logic [KEY_BITS-1:0] a_key,
   input  logic [63:0]         c_ident,
   input  logic [KEY_BITS-1:0] c_key,
   input  logic [KEY_BITS-1:0] target,
   output logic                closer
);

   logic [KEY_BITS+63:0] a_rank;
   logic [KEY_BITS+63:0] c_rank;

   // distance, then shard, then node, ids offset to unsigned order
   assign a_rank = {a_key ^ target, ~a_ident[63], a_ident[62:32], ~a_ident[31], a_ident[30:0]};
   assign c_rank = {c_key ^ target, ~c_ident[63], c_ident[62:32], ~c_ident[31], c_ident[30:0]};
   assign closer = a_rank < c_rank;

endmodule

/* sv/xor_kbucket_peer_table.sv */
// errors go straight to the response; other table actions load the bucket fill, scan the
// bucket entry by entry, then act; removal and refresh also shift each entry behind the
// peer's slot; a neighbour query gathers buckets entry by entry, checks each gathered entry
// against every held candidate for duplicates, then picks each result by a scan of the rest
// each memory has a single read port; one item at a time
// synchronous reset clears home_key, then a clearing pass empties the buckets
`include "assert_macros.svh"

module xor_kbucket_peer_table #(
   parameter int KEY_BITS        = kbt_pkg::KEY_BITS_DEF,
   parameter int BUCKET_CAPACITY = kbt_pkg::BUCKET_CAPACITY_DEF,
   parameter int MAX_NEIGHBORS   = kbt_pkg::MAX_NEIGHBORS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [63:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_node_id,
   input  logic signed [31:0] req_shard_id,
   input  logic [63:0]        req_peer_key,
   input  logic [4:0]         req_want_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic               rsp_found,
   output logic               rsp_has_room,
   output logic [10:0]        rsp_table_count,
   output logic               rsp_neighbor_valid,
   output logic signed [31:0] rsp_neighbor_node,
   output logic signed [31:0] rsp_neighbor_shard,
   output logic               rsp_last
);

   import kbt_pkg::*;

   // bucket and slot geometry
   localparam int BW     = $clog2(KEY_BITS);
   localparam int IW     = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;
   localparam int FW     = $clog2(BUCKET_CAPACITY + 1);
   localparam int EDEPTH = KEY_BITS << IW;
   localparam int EAW    = BW + IW;
   localparam int EW     = 64 + KEY_BITS;
   localparam int SLOTS  = KEY_BITS * BUCKET_CAPACITY;
   localparam int TW     = $clog2(SLOTS + 1);
   // candidate buffer: at most one bucket beyond the wanted count
   localparam int NLIM   = (MAX_NEIGHBORS < RESULT_LIMIT) ? MAX_NEIGHBORS : RESULT_LIMIT;
   localparam int NW     = $clog2(NLIM + 1);
   localparam int CDEPTH = NLIM + BUCKET_CAPACITY - 1;
   localparam int CIW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int CW     = $clog2(CDEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_FIND, S_FIND_W, S_ACT, S_SHIFT, S_SHIFT_W, S_DONE,
      S_QSTART, S_QBUCK, S_QENT, S_QENT_W, S_DUP, S_DUP_W, S_QFIN,
      S_SELR, S_SELR_W, S_SCAN, S_SCAN_W, S_EMIT,
      S_CLEAR, S_FLOAD, S_QLOAD
   } state_type;

   state_type state_ff;

   // configuration and table bookkeeping
   logic [63:0]         home_ff;
   logic [FW-1:0]       cur_fill_ff;
   logic [BW-1:0]       clr_ff;
   logic [TW-1:0]       total_ff;

   // item being worked on
   logic [2:0]          act_ff;
   logic [63:0]         ident_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [4:0]          want_ff;
   logic [BW-1:0]       b_ff;
   logic [BW-1:0]       bk_ff;
   logic                up_ff;
   logic [FW-1:0]       ei_ff;
   logic                found_ff;
   logic                room_en_ff;
   logic [2:0]          status_ff;

   // query bookkeeping
   logic [NW-1:0]       n_ff;
   logic [CW-1:0]       nc_ff;
   logic [CW-1:0]       ci_ff;
   logic [CW-1:0]       r_ff;
   logic [EW-1:0]       new_ff;
   logic [EW-1:0]       hold_ff;
   logic [EW-1:0]       best_ff;
   logic [CW-1:0]       best_idx_ff;

   // output register
   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic                rsp_found_ff;
   logic                rsp_has_room_ff;
   logic [10:0]         rsp_table_count_ff;
   logic                rsp_neighbor_valid_ff;
   logic [63:0]         rsp_ident_ff;
   logic                rsp_last_ff;

   // memory ports
   logic                e_we;
   logic [EAW-1:0]      e_waddr;
   logic [EW-1:0]       e_wdata;
   logic                e_re;
   logic [EAW-1:0]      e_raddr;
   logic [EW-1:0]       e_rdata;
   logic                c_we;
   logic [CIW-1:0]      c_waddr;
   logic [EW-1:0]       c_wdata;
   logic                c_re;
   logic [CIW-1:0]      c_raddr;
   logic [EW-1:0]       c_rdata;
   logic                f_we;
   logic [BW-1:0]       f_waddr;
   logic [FW-1:0]       f_wdata;
   logic                f_re;
   logic [BW-1:0]       f_raddr;
   logic [FW-1:0]       f_rdata;

   logic [FW-1:0]       fill_cur;
   logic [FW-1:0]       ei_nx;
   logic                room;
   logic                out_free;
   logic                rsp_load;
   logic                is_closer;
   logic [KEY_BITS-1:0] req_key;
   logic [KEY_BITS-1:0] req_dist;
   logic [BW-1:0]       req_bucket;
   logic                last_pick;

   assign fill_cur   = cur_fill_ff;
   assign ei_nx      = ei_ff + 1'b1;
   assign room       = fill_cur < FW'(BUCKET_CAPACITY);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = out_free && ((state_ff == S_DONE) || (state_ff == S_EMIT));
   assign req_key    = req_peer_key[KEY_BITS-1:0];
   assign req_dist   = req_key ^ home_ff[KEY_BITS-1:0];
   assign req_bucket = BW'(top_bit64(64'(req_dist)));
   assign last_pick  = (r_ff + 1'b1) == CW'(n_ff);

   // home key changes only between items
   assign csr_ready = state_ff == S_IDLE;
   assign req_stall = state_ff != S_IDLE;

   kbt_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_en   (e_re),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   kbt_ram #(.WIDTH(EW), .DEPTH(CDEPTH)) u_cand_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_en   (c_re),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   // bucket fill counts, one entry per bucket
   kbt_ram #(.WIDTH(FW), .DEPTH(KEY_BITS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_en   (f_re),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   // candidate from memory against the best held so far
   kbt_closer #(.KEY_BITS(KEY_BITS)) u_closer (
      .a_ident (c_rdata[EW-1 -: 64]),
      .a_key   (c_rdata[KEY_BITS-1:0]),
      .c_ident (best_ff[EW-1 -: 64]),
      .c_key   (best_ff[KEY_BITS-1:0]),
      .target  (key_ff),
      .closer  (is_closer)
   );

   // memory access per state
   always_comb begin
      e_we    = 1'b0;
      e_waddr = {bk_ff, ei_ff[IW-1:0]};
      e_wdata = {ident_ff, key_ff};
      e_re    = 1'b0;
      e_raddr = {bk_ff, ei_ff[IW-1:0]};
      c_we    = 1'b0;
      c_waddr = nc_ff[CIW-1:0];
      c_wdata = new_ff;
      c_re    = 1'b0;
      c_raddr = ci_ff[CIW-1:0];
      f_we    = 1'b0;
      f_waddr = bk_ff;
      f_wdata = cur_fill_ff;
      f_re    = 1'b0;
      f_raddr = bk_ff;
      case (state_ff)
         S_IDLE: begin
            // fetch the fill of the peer's bucket ahead of acceptance
            f_re    = 1'b1;
            f_raddr = req_bucket;
         end
         S_CLEAR: begin
            f_we    = 1'b1;
            f_waddr = clr_ff;
            f_wdata = '0;
         end
         S_FIND: begin
            e_re = ei_ff != fill_cur;
         end
         S_ACT: begin
            // append at the tail of the bucket
            e_waddr = {bk_ff, fill_cur[IW-1:0]};
            e_we    = (act_ff == ACT_INSERT) && !found_ff && room;
            f_we    = (act_ff == ACT_INSERT) && !found_ff && room;
            f_wdata = fill_cur + 1'b1;
         end
         S_SHIFT: begin
            // read the follower, or place the refreshed peer at the tail
            e_raddr = {bk_ff, ei_nx[IW-1:0]};
            e_re    = ei_nx < fill_cur;
            e_we    = !(ei_nx < fill_cur) && (act_ff != ACT_REMOVE);
            f_we    = !(ei_nx < fill_cur) && (act_ff == ACT_REMOVE);
            f_wdata = fill_cur - 1'b1;
         end
         S_SHIFT_W: begin
            e_we    = 1'b1;
            e_wdata = e_rdata;
         end
         S_QBUCK: begin
            f_re = 1'b1;
         end
         S_QENT: begin
            e_re = ei_ff != fill_cur;
         end
         S_DUP: begin
            c_we = ci_ff == nc_ff;
            c_re = ci_ff != nc_ff;
         end
         S_SELR: begin
            c_re    = 1'b1;
            c_raddr = r_ff[CIW-1:0];
         end
         S_SCAN: begin
            c_re = ci_ff != nc_ff;
         end
         S_EMIT: begin
            // swap the displaced head into the winner's place
            c_we    = out_free;
            c_waddr = best_idx_ff[CIW-1:0];
            c_wdata = hold_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         home_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         nc_ff        <= '0;
         cur_fill_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            home_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            // zero every bucket fill after reset
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BW'(KEY_BITS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  act_ff     <= req_action;
                  ident_ff   <= {req_shard_id, req_node_id};
                  key_ff     <= req_key;
                  want_ff    <= req_want_count;
                  b_ff       <= req_bucket;
                  bk_ff      <= req_bucket;
                  up_ff      <= 1'b0;
                  ei_ff      <= '0;
                  found_ff   <= 1'b0;
                  room_en_ff <= 1'b0;
                  status_ff  <= ST_OK;
                  if (req_action > ACT_QUERY) begin
                     state_ff <= S_DONE;
                  end else if (req_dist == '0) begin
                     status_ff <= ST_HOME;
                     state_ff  <= S_DONE;
                  end else if (req_action == ACT_QUERY) begin
                     state_ff <= S_QSTART;
                  end else begin
                     room_en_ff <= 1'b1;
                     state_ff   <= S_FLOAD;
                  end
               end
            end
            S_FLOAD: begin
               cur_fill_ff <= f_rdata;
               state_ff    <= S_FIND;
            end
            // linear search of the peer's bucket
            S_FIND: begin
               if (ei_ff == fill_cur) begin
                  state_ff <= S_ACT;
               end else begin
                  state_ff <= S_FIND_W;
               end
            end
            S_FIND_W: begin
               if (e_rdata[EW-1 -: 64] == ident_ff) begin
                  found_ff <= 1'b1;
                  state_ff <= S_ACT;
               end else begin
                  ei_ff    <= ei_nx;
                  state_ff <= S_FIND;
               end
            end
            S_ACT: begin
               state_ff <= S_DONE;
               case (act_ff)
                  ACT_INSERT: begin
                     if (found_ff) begin
                        status_ff <= ST_PRESENT;
                     end else if (!room) begin
                        status_ff <= ST_FULL;
                     end else begin
                        cur_fill_ff <= fill_cur + 1'b1;
                        total_ff    <= total_ff + 1'b1;
                     end
                  end
                  ACT_REMOVE, ACT_UPDATE: begin
                     if (!found_ff) begin
                        status_ff <= ST_ABSENT;
                     end else begin
                        state_ff <= S_SHIFT;
                     end
                  end
                  ACT_UPDATE_KNOWN: begin
                     if (found_ff) begin
                        state_ff <= S_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // close the gap behind the removed or refreshed peer's slot
            S_SHIFT: begin
               if (ei_nx < fill_cur) begin
                  state_ff <= S_SHIFT_W;
               end else begin
                  if (act_ff == ACT_REMOVE) begin
                     cur_fill_ff <= fill_cur - 1'b1;
                     total_ff    <= total_ff - 1'b1;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_SHIFT_W: begin
               ei_ff    <= ei_nx;
               state_ff <= S_SHIFT;
            end
            // single result of a table action, error or empty query
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_status_ff         <= status_ff;
                  rsp_found_ff          <= found_ff;
                  rsp_has_room_ff       <= room_en_ff & room;
                  rsp_table_count_ff    <= 11'(total_ff);
                  rsp_neighbor_valid_ff <= 1'b0;
                  rsp_ident_ff          <= '0;
                  rsp_last_ff           <= 1'b1;
                  state_ff              <= S_IDLE;
               end
            end
            S_QSTART: begin
               nc_ff <= '0;
               if (want_ff > 5'(NLIM)) begin
                  n_ff <= NW'(NLIM);
               end else begin
                  n_ff <= NW'(want_ff);
               end
               if (want_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_QBUCK;
               end
            end
            // gather whole buckets until enough candidates are held or no bucket is left
            S_QBUCK: begin
               if (nc_ff >= CW'(n_ff)) begin
                  state_ff <= S_QFIN;
               end else begin
                  ei_ff    <= '0;
                  state_ff <= S_QLOAD;
               end
            end
            S_QLOAD: begin
               cur_fill_ff <= f_rdata;
               state_ff    <= S_QENT;
            end
            S_QENT: begin
               if (ei_ff == fill_cur) begin
                  if (!up_ff) begin
                     if (bk_ff == '0) begin
                        if (b_ff == BW'(KEY_BITS - 1)) begin
                           state_ff <= S_QFIN;
                        end else begin
                           bk_ff    <= b_ff + 1'b1;
                           up_ff    <= 1'b1;
                           state_ff <= S_QBUCK;
                        end
                     end else begin
                        bk_ff    <= bk_ff - 1'b1;
                        state_ff <= S_QBUCK;
                     end
                  end else if (bk_ff == BW'(KEY_BITS - 1)) begin
                     state_ff <= S_QFIN;
                  end else begin
                     bk_ff    <= bk_ff + 1'b1;
                     state_ff <= S_QBUCK;
                  end
               end else begin
                  state_ff <= S_QENT_W;
               end
            end
            S_QENT_W: begin
               new_ff   <= e_rdata;
               ci_ff    <= '0;
               state_ff <= S_DUP;
            end
            // identity seen before keeps its first key
            S_DUP: begin
               if (ci_ff == nc_ff) begin
                  nc_ff    <= nc_ff + 1'b1;
                  ei_ff    <= ei_nx;
                  state_ff <= S_QENT;
               end else begin
                  state_ff <= S_DUP_W;
               end
            end
            S_DUP_W: begin
               if (c_rdata[EW-1 -: 64] == new_ff[EW-1 -: 64]) begin
                  ei_ff    <= ei_nx;
                  state_ff <= S_QENT;
               end else begin
                  ci_ff    <= ci_ff + 1'b1;
                  state_ff <= S_DUP;
               end
            end
            S_QFIN: begin
               r_ff <= '0;
               if (nc_ff < CW'(n_ff)) begin
                  n_ff <= NW'(nc_ff);
               end
               if (nc_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SELR;
               end
            end
            // selection sort, one result per pass
            S_SELR: begin
               state_ff <= S_SELR_W;
            end
            S_SELR_W: begin
               hold_ff     <= c_rdata;
               best_ff     <= c_rdata;
               best_idx_ff <= r_ff;
               ci_ff       <= r_ff + 1'b1;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               if (ci_ff == nc_ff) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_SCAN_W;
               end
            end
            S_SCAN_W: begin
               if (is_closer) begin
                  best_ff     <= c_rdata;
                  best_idx_ff <= ci_ff;
               end
               ci_ff    <= ci_ff + 1'b1;
               state_ff <= S_SCAN;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_status_ff         <= ST_OK;
                  rsp_found_ff          <= 1'b0;
                  rsp_has_room_ff       <= 1'b0;
                  rsp_table_count_ff    <= 11'(total_ff);
                  rsp_neighbor_valid_ff <= 1'b1;
                  rsp_ident_ff          <= best_ff[EW-1 -: 64];
                  rsp_last_ff           <= last_pick;
                  if (last_pick) begin
                     state_ff <= S_IDLE;
                  end else begin
                     r_ff     <= r_ff + 1'b1;
                     state_ff <= S_SELR;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_has_room       = rsp_has_room_ff;
   assign rsp_table_count    = rsp_table_count_ff;
   assign rsp_neighbor_valid = rsp_neighbor_valid_ff;
   assign rsp_neighbor_node  = rsp_ident_ff[31:0];
   assign rsp_neighbor_shard = rsp_ident_ff[63:32];
   assign rsp_last           = rsp_last_ff;

   // peer total never beyond the slot count
   `KBT_ASSERT_ALWAYS(a_total_bound, clock, reset, total_ff <= TW'(SLOTS))
   // candidate buffer never overflows
   `KBT_ASSERT_ALWAYS(a_cand_bound, clock, reset, nc_ff <= CW'(CDEPTH))
   // a result without a neighbor always ends its item
   `KBT_ASSERT_IMPLY(a_null_last, clock, reset, rsp_valid_ff && !rsp_neighbor_valid_ff, rsp_last_ff)

endmodule
